>>> sv/gld_pkg.sv
package gld_pkg;

    localparam int TABLE_ENTRIES    = 4096;
    localparam int ADDR_BITS        = $clog2(TABLE_ENTRIES);
    localparam int MAX_CODE_BITS    = 12;
    localparam int PIXEL_COUNT_BITS = 28;
    localparam int STACK_BITS       = ADDR_BITS + 1;
    localparam int FREE_BITS        = 13;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_FETCH = 2'd2;

    localparam logic CFG_MIN_CODE_SIZE = 1'b0;
    localparam logic CFG_PIXEL_TOTAL   = 1'b1;

    typedef enum logic [1:0] {
        OP_START,
        OP_BYTE,
        OP_FETCH,
        OP_BAD
    } op_t;

    typedef enum logic [2:0] {
        ST_PIXEL = 3'd0,
        ST_TAKEN = 3'd1,
        ST_NEED  = 3'd2,
        ST_DONE  = 3'd3,
        ST_ERR   = 3'd4,
        ST_FULL  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_RUN,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       final_byte;
    } item_t;

endpackage

>>> sv/gld_front.sv
module gld_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          func,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output logic                q_valid,
    output gld_pkg::item_t      q_item,
    input  logic                q_pop
);

    gld_pkg::item_t item_reg [gld_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    gld_pkg::item_t new_item;
    logic           push;

    always_comb
    begin
        new_item.data_byte  = data_byte;
        new_item.final_byte = final_byte;
        case (func)
            gld_pkg::FUNC_START: new_item.op = gld_pkg::OP_START;
            gld_pkg::FUNC_BYTE:  new_item.op = gld_pkg::OP_BYTE;
            gld_pkg::FUNC_FETCH: new_item.op = gld_pkg::OP_FETCH;
            default:             new_item.op = gld_pkg::OP_BAD;
        endcase
    end

    assign in_ready = (count_reg != 2'(gld_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = item_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> sv/gld_back.sv
module gld_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  gld_pkg::item_t      q_item,
    output logic                q_pop,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [27:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          pixel_index,
    output logic [2:0]          status,
    output logic                last_pixel
);

    localparam int AB = gld_pkg::ADDR_BITS;
    localparam int SB = gld_pkg::STACK_BITS;
    localparam int FB = gld_pkg::FREE_BITS;
    localparam int PB = gld_pkg::PIXEL_COUNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CODE = 4'b0010,
        S_WALK = 4'b0100,
        S_POP  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [3:0]        mcs_reg;
    logic [PB-1:0]     total_reg;
    logic [SB-1:0]     stack_top_reg, stack_top_next;
    logic [31:0]       bitbuf_reg, bitbuf_next;
    logic [5:0]        pending_reg, pending_next;
    logic              ended_reg, ended_next;
    logic [FB-1:0]     nfc_reg, nfc_next;
    logic [3:0]        cw_reg, cw_next;
    logic [AB-1:0]     prev_reg, prev_next;
    logic              pv_reg, pv_next;
    logic [7:0]        first_reg, first_next;
    logic [PB-1:0]     pixels_reg, pixels_next;
    gld_pkg::phase_t   phase_reg, phase_next;
    logic [AB-1:0]     cur_reg, cur_next;
    logic [AB-1:0]     in_code_reg, in_code_next;

    logic              out_valid_reg;
    logic [7:0]        pixel_index_reg;
    gld_pkg::status_t  status_reg;
    logic              last_reg;

    logic              res_load;
    gld_pkg::status_t  res_status;
    logic [7:0]        res_pix;
    logic              res_last;

    logic [AB-1:0]     prefix_mem [gld_pkg::TABLE_ENTRIES];
    logic [7:0]        suffix_mem [gld_pkg::TABLE_ENTRIES];
    logic [7:0]        stack_mem  [gld_pkg::TABLE_ENTRIES];
    logic [AB-1:0]     pre_rd_reg;
    logic [7:0]        suf_rd_reg;
    logic [7:0]        stk_rd_reg;

    logic              tbl_we;
    logic [AB-1:0]     tbl_raddr;
    logic              stk_we;
    logic [7:0]        stk_wdata;
    logic [AB-1:0]     stk_raddr;

    logic [16:0]       clr;
    logic [FB-1:0]     nfc_restart;
    logic [3:0]        cw_restart;
    logic [31:0]       code_mask;
    logic [AB-1:0]     code;
    logic [FB-1:0]     nfc_inc;
    logic [PB-1:0]     pixels_inc;

    assign clr         = 17'd1 << mcs_reg;
    assign nfc_restart = FB'(clr + 17'd2);
    assign cw_restart  = mcs_reg + 4'd1;
    assign code_mask   = (32'd1 << cw_reg) - 32'd1;
    assign code        = AB'(bitbuf_reg & code_mask);
    assign nfc_inc     = nfc_reg + FB'(1);
    assign pixels_inc  = pixels_reg + PB'(1);

    always_comb
    begin
        state_next     = state_reg;
        stack_top_next = stack_top_reg;
        bitbuf_next    = bitbuf_reg;
        pending_next   = pending_reg;
        ended_next     = ended_reg;
        nfc_next       = nfc_reg;
        cw_next        = cw_reg;
        prev_next      = prev_reg;
        pv_next        = pv_reg;
        first_next     = first_reg;
        pixels_next    = pixels_reg;
        phase_next     = phase_reg;
        cur_next       = cur_reg;
        in_code_next   = in_code_reg;
        q_pop          = 1'b0;
        res_load       = 1'b0;
        res_status     = gld_pkg::ST_ERR;
        res_pix        = 8'd0;
        res_last       = 1'b0;
        tbl_we         = 1'b0;
        tbl_raddr      = cur_reg;
        stk_we         = 1'b0;
        stk_wdata      = cur_reg[7:0];
        stk_raddr      = AB'(stack_top_reg - SB'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop    = 1'b1;
                    res_load = 1'b1;
                    case (q_item.op)
                        gld_pkg::OP_START:
                        begin
                            stack_top_next = '0;
                            bitbuf_next    = '0;
                            pending_next   = '0;
                            ended_next     = 1'b0;
                            first_next     = '0;
                            pixels_next    = '0;
                            phase_next     = gld_pkg::PH_RUN;
                            nfc_next       = nfc_restart;
                            cw_next        = cw_restart;
                            pv_next        = 1'b0;
                            prev_next      = '0;
                            res_status     = gld_pkg::ST_TAKEN;
                        end
                        gld_pkg::OP_BYTE:
                        begin
                            if (ended_reg)
                            begin
                                res_status = gld_pkg::ST_TAKEN;
                            end
                            else if (pending_reg > 6'd24)
                            begin
                                res_status = gld_pkg::ST_FULL;
                            end
                            else
                            begin
                                bitbuf_next  = bitbuf_reg
                                             | ({24'd0, q_item.data_byte} << pending_reg);
                                pending_next = pending_reg + 6'd8;
                                if (q_item.final_byte)
                                begin
                                    ended_next = 1'b1;
                                end
                                res_status = gld_pkg::ST_TAKEN;
                            end
                        end
                        gld_pkg::OP_FETCH:
                        begin
                            if (phase_reg == gld_pkg::PH_ERR)
                            begin
                                res_status = gld_pkg::ST_ERR;
                            end
                            else if (phase_reg == gld_pkg::PH_DONE)
                            begin
                                res_status = gld_pkg::ST_DONE;
                            end
                            else if (pixels_reg >= total_reg)
                            begin
                                phase_next = gld_pkg::PH_DONE;
                                res_status = gld_pkg::ST_DONE;
                            end
                            else if (mcs_reg < 4'd2 || mcs_reg > 4'd8)
                            begin
                                phase_next = gld_pkg::PH_ERR;
                                res_status = gld_pkg::ST_ERR;
                            end
                            else
                            begin
                                res_load   = 1'b0;
                                state_next = S_CODE;
                            end
                        end
                        default:
                        begin
                            res_status = gld_pkg::ST_ERR;
                        end
                    endcase
                end
            end

            S_CODE:
            begin
                if (stack_top_reg != '0)
                begin
                    stack_top_next = stack_top_reg - SB'(1);
                    state_next     = S_POP;
                end
                else if (cw_reg == 4'd0 || cw_reg > 4'(gld_pkg::MAX_CODE_BITS))
                begin
                    phase_next = gld_pkg::PH_ERR;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (pending_reg < {2'b00, cw_reg})
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (ended_reg)
                    begin
                        phase_next = gld_pkg::PH_ERR;
                    end
                    else
                    begin
                        res_status = gld_pkg::ST_NEED;
                    end
                end
                else
                begin
                    bitbuf_next  = bitbuf_reg >> cw_reg;
                    pending_next = pending_reg - {2'b00, cw_reg};
                    if (17'(code) == clr)
                    begin
                        nfc_next  = nfc_restart;
                        cw_next   = cw_restart;
                        pv_next   = 1'b0;
                        prev_next = '0;
                    end
                    else if (17'(code) == clr + 17'd1
                             || FB'(code) > nfc_reg
                             || (FB'(code) == nfc_reg && !pv_reg))
                    begin
                        phase_next = gld_pkg::PH_ERR;
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        in_code_next = code;
                        state_next   = S_WALK;
                        if (FB'(code) == nfc_reg)
                        begin
                            // KwKwK: the new string ends in its own first symbol
                            stk_we         = 1'b1;
                            stk_wdata      = first_reg;
                            stack_top_next = stack_top_reg + SB'(1);
                            cur_next       = prev_reg;
                        end
                        else
                        begin
                            cur_next = code;
                        end
                        tbl_raddr = cur_next;
                    end
                end
            end

            S_WALK:
            begin
                if (17'(cur_reg) >= clr)
                begin
                    if (stack_top_reg >= SB'(gld_pkg::TABLE_ENTRIES))
                    begin
                        phase_next = gld_pkg::PH_ERR;
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        stk_we         = 1'b1;
                        stk_wdata      = suf_rd_reg;
                        stack_top_next = stack_top_reg + SB'(1);
                        cur_next       = pre_rd_reg;
                        tbl_raddr      = pre_rd_reg;
                    end
                end
                else
                begin
                    first_next = cur_reg[7:0];
                    if (stack_top_reg >= SB'(gld_pkg::TABLE_ENTRIES))
                    begin
                        phase_next = gld_pkg::PH_ERR;
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        stk_we         = 1'b1;
                        stk_wdata      = cur_reg[7:0];
                        stack_top_next = stack_top_reg + SB'(1);
                        if (pv_reg && nfc_reg < FB'(gld_pkg::TABLE_ENTRIES))
                        begin
                            tbl_we   = 1'b1;
                            nfc_next = nfc_inc;
                            if (nfc_inc >= (FB'(1) << cw_reg)
                                && cw_reg < 4'(gld_pkg::MAX_CODE_BITS))
                            begin
                                cw_next = cw_reg + 4'd1;
                            end
                        end
                        prev_next  = in_code_reg;
                        pv_next    = 1'b1;
                        state_next = S_CODE;
                    end
                end
            end

            S_POP:
            begin
                res_load    = 1'b1;
                res_status  = gld_pkg::ST_PIXEL;
                res_pix     = stk_rd_reg;
                pixels_next = pixels_inc;
                if (pixels_inc >= total_reg)
                begin
                    res_last   = 1'b1;
                    phase_next = gld_pkg::PH_DONE;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mcs_reg       <= 4'd8;
            total_reg     <= PB'(1);
            stack_top_reg <= '0;
            bitbuf_reg    <= '0;
            pending_reg   <= '0;
            ended_reg     <= 1'b0;
            nfc_reg       <= FB'(258);
            cw_reg        <= 4'd9;
            prev_reg      <= '0;
            pv_reg        <= 1'b0;
            first_reg     <= '0;
            pixels_reg    <= '0;
            phase_reg     <= gld_pkg::PH_RUN;
            cur_reg       <= '0;
            in_code_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stack_top_reg <= stack_top_next;
            bitbuf_reg    <= bitbuf_next;
            pending_reg   <= pending_next;
            ended_reg     <= ended_next;
            nfc_reg       <= nfc_next;
            cw_reg        <= cw_next;
            prev_reg      <= prev_next;
            pv_reg        <= pv_next;
            first_reg     <= first_next;
            pixels_reg    <= pixels_next;
            phase_reg     <= phase_next;
            cur_reg       <= cur_next;
            in_code_reg   <= in_code_next;
            if (cfg_valid)
            begin
                if (cfg_index == gld_pkg::CFG_MIN_CODE_SIZE)
                begin
                    mcs_reg <= cfg_data[3:0];
                end
                else
                begin
                    total_reg <= cfg_data[PB-1:0];
                end
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            pixel_index_reg <= res_pix;
            status_reg      <= res_status;
            last_reg        <= res_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            prefix_mem[nfc_reg[AB-1:0]] <= prev_reg;
            suffix_mem[nfc_reg[AB-1:0]] <= cur_reg[7:0];
        end
        pre_rd_reg <= prefix_mem[tbl_raddr];
        suf_rd_reg <= suffix_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stack_top_reg[AB-1:0]] <= stk_wdata;
        end
        stk_rd_reg <= stack_mem[stk_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign status      = status_reg;
    assign last_pixel  = last_reg;

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid_reg && state_reg == S_IDLE)
        else $error("transaction taken while a result is held");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 6'd32)
        else $error("bit buffer overfilled");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_top_reg <= SB'(gld_pkg::TABLE_ENTRIES))
        else $error("expand stack beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CODE && state_next == S_POP |-> stack_top_reg != '0)
        else $error("pop from empty stack");

    a_pixel_only_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && res_status == gld_pkg::ST_PIXEL |-> state_reg == S_POP)
        else $error("pixel result outside pop");

endmodule

>>> sv/gif_lzw_decoder_unit.sv
// Channel | Signals                                        | Direction
// input   | in_valid/in_ready, func, data_byte, final_byte | into block
// result  | out_valid/out_ready, pixel_index, status, last_pixel | out of block
// config  | cfg_valid/cfg_ready, cfg_index, cfg_data       | into block
//
// Start, byte, undefined and ended or failed fetch transactions register their
// result in the cycle after leaving the queue. Other fetches pop a stacked symbol
// or read codes and stack their chains first (one dictionary read per cycle).
// A 2-entry queue takes input while the result register waits on out_ready.
// Reset is asynchronous; the dictionary and stack memories are not cleared.
module gif_lzw_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_index,
    output logic [2:0]  status,
    output logic        last_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [27:0] cfg_data
);

    logic           q_valid;
    logic           q_pop;
    gld_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    gld_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    gld_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .status      (status),
        .last_pixel  (last_pixel)
    );

endmodule
